// ===== hw/rtl/power_path_mode_controller_defines.svh =====
// Assertion helpers for the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef POWER_PATH_MODE_CONTROLLER_DEFINES_SVH
`define POWER_PATH_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define PPMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppmc: same-cycle check failed");

// Next-cycle implication.
`define PPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppmc: next-cycle check failed");

`endif

// ===== hw/rtl/ppmc_pkg.sv =====
package ppmc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL     = 2'd2;

  localparam logic [6:0] COMPARE_COUNT_RST = 7'd10;
  localparam logic [2:0] NORMAL_LEVEL_RST  = 3'd3;
  localparam logic [2:0] LOW_LEVEL_RST     = 3'd5;

  // Input codes
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_REQUEST = 1'b1;
  localparam logic CMD_ENTER   = 1'b0;
  localparam logic CMD_EXIT    = 1'b1;

  localparam logic [3:0] LEVEL_FULL    = 4'd0;
  localparam logic [3:0] LEVEL_EJECTED = 4'd7;
  localparam logic [3:0] LEVEL_UNKNOWN = 4'd8;

  // Result kinds
  localparam logic [2:0] KIND_SOURCE = 3'd0;
  localparam logic [2:0] KIND_EXTRA  = 3'd1;
  localparam logic [2:0] KIND_ACK    = 3'd2;
  localparam logic [2:0] KIND_MUTE   = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;

  // Input source
  localparam logic [2:0] SRC_IGNORE   = 3'd0;
  localparam logic [2:0] SRC_DC       = 3'd1;
  localparam logic [2:0] SRC_USB      = 3'd2;
  localparam logic [2:0] SRC_USB_NONE = 3'd3;
  localparam logic [2:0] SRC_NONE     = 3'd4;

  // Battery source
  localparam logic [1:0] BAT_IGNORE = 2'd0;
  localparam logic [1:0] BAT_NONE   = 2'd1;
  localparam logic [1:0] BAT_INT    = 2'd2;
  localparam logic [1:0] BAT_EXT    = 2'd3;

  // Extra commands
  localparam logic [2:0] EXTRA_IGNORE  = 3'd0;
  localparam logic [2:0] EXTRA_CHG_ON  = 3'd1;
  localparam logic [2:0] EXTRA_CHG_OFF = 3'd2;
  localparam logic [2:0] EXTRA_SOL_ON  = 3'd3;
  localparam logic [2:0] EXTRA_SOL_OFF = 3'd4;
  localparam logic [2:0] EXTRA_A5V_SET = 3'd5;
  localparam logic [2:0] EXTRA_A5V_CLR = 3'd6;

  // Power modes
  localparam logic [2:0] PM_DC        = 3'd0;
  localparam logic [2:0] PM_USB_INT   = 3'd1;
  localparam logic [2:0] PM_USB_EXT   = 3'd2;
  localparam logic [2:0] PM_NORMAL    = 3'd3;
  localparam logic [2:0] PM_LOW       = 3'd4;
  localparam logic [2:0] PM_SHUTDOWN  = 3'd5;
  localparam logic [2:0] PM_EMERGENCY = 3'd6;
  localparam logic [2:0] PM_NONE      = 3'd7;

  // Actions passed from front to back
  localparam logic [1:0] ACT_ACK  = 2'd0;
  localparam logic [1:0] ACT_EXIT = 2'd1;
  localparam logic [1:0] ACT_MODE = 2'd2;

  // Steps of a mode action
  localparam logic [2:0] STEP_REPORT  = 3'd0;
  localparam logic [2:0] STEP_SOURCE  = 3'd1;
  localparam logic [2:0] STEP_CHARGER = 3'd2;
  localparam logic [2:0] STEP_SOL_ON  = 3'd3;
  localparam logic [2:0] STEP_A5V_SET = 3'd4;
  localparam logic [2:0] STEP_MUTE_ON = 3'd5;
  // Steps of an emergency exit
  localparam logic [2:0] STEP_SOL_OFF = 3'd0;
  localparam logic [2:0] STEP_UNMUTE  = 3'd1;
  localparam logic [2:0] STEP_A5V_CLR = 3'd2;
  localparam logic [2:0] STEP_RESTORE = 3'd3;

  typedef struct packed {
    logic        mode;
    logic        emergency_cmd;
    logic        dc_plugged;
    logic        usb_plugged;
    logic [3:0]  int_batt_level;
    logic [3:0]  ext_batt_level;
    logic [15:0] int_batt_volt;
    logic [15:0] ext_batt_volt;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] input_source;
    logic [1:0] battery_source;
    logic [2:0] extra_cmd;
    logic       mute;
    logic [2:0] pwr_mode;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] act;
    logic       report;
    logic [2:0] pm;
    logic [2:0] src;
    logic [1:0] bat;
    logic [2:0] extra;
  } action_t;

endpackage

// ===== hw/rtl/ppmc_front.sv =====
// Accept items, update controller state and emit at most one action per item.
module ppmc_front import ppmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  take,
  input  in_item_t              item,
  output logic                  act_valid,
  output action_t               act
);

  logic [6:0] compare_count_r;
  logic [2:0] normal_level_r;
  logic [2:0] low_level_r;

  logic       in_emergency_r, in_emergency_nxt;
  logic       enter_req_r, enter_req_nxt;
  logic       exit_req_r, exit_req_nxt;
  logic       int_higher_r, int_higher_nxt;
  logic [6:0] mismatch_cnt_r, mismatch_cnt_nxt;

  logic       mismatch;
  logic [3:0] nl, ll;

  assign nl = {1'b0, normal_level_r};
  assign ll = {1'b0, low_level_r};
  assign mismatch = int_higher_r ? (item.int_batt_volt < item.ext_batt_volt)
                                 : (item.int_batt_volt > item.ext_batt_volt);

  always_comb begin
    in_emergency_nxt = in_emergency_r;
    enter_req_nxt    = enter_req_r;
    exit_req_nxt     = exit_req_r;
    int_higher_nxt   = int_higher_r;
    mismatch_cnt_nxt = mismatch_cnt_r;
    act_valid        = 1'b0;
    act              = '0;
    act.act          = ACT_MODE;
    act.report       = 1'b1;
    act.src          = SRC_NONE;
    act.bat          = BAT_INT;
    act.extra        = EXTRA_CHG_OFF;
    act.pm           = PM_NONE;

    if (take) begin
      if (item.mode == REQ_REQUEST) begin
        act_valid = 1'b1;
        act.act   = ACT_ACK;
        if (!in_emergency_r && item.emergency_cmd == CMD_ENTER) enter_req_nxt = 1'b1;
        if (in_emergency_r && item.emergency_cmd == CMD_EXIT)   exit_req_nxt  = 1'b1;
      end else if (in_emergency_r) begin
        if (exit_req_r) begin
          act_valid        = 1'b1;
          act.act          = ACT_EXIT;
          in_emergency_nxt = 1'b0;
          enter_req_nxt    = 1'b0;
          exit_req_nxt     = 1'b0;
        end
      end else begin
        act_valid = 1'b1;
        if (item.dc_plugged) begin
          act.pm    = PM_DC;
          act.src   = SRC_DC;
          act.bat   = BAT_NONE;
          act.extra = (item.ext_batt_level < LEVEL_EJECTED) ? EXTRA_CHG_ON : EXTRA_CHG_OFF;
        end else if (item.usb_plugged && item.ext_batt_level == LEVEL_FULL) begin
          act.pm  = PM_USB_INT;
          act.src = SRC_USB;
          act.bat = BAT_EXT;
        end else if (item.usb_plugged) begin
          act.pm  = PM_USB_EXT;
          act.src = SRC_USB_NONE;
          act.bat = BAT_INT;
        end else if (item.int_batt_level == LEVEL_UNKNOWN ||
                     item.ext_batt_level == LEVEL_UNKNOWN) begin
          act.pm     = PM_NORMAL;
          act.report = 1'b0;
        end else if (enter_req_r) begin
          act.pm = PM_EMERGENCY;
        end else if (item.int_batt_level < nl || item.ext_batt_level < nl) begin
          act.pm = PM_NORMAL;
        end else if (item.int_batt_level < ll || item.ext_batt_level < ll) begin
          act.pm = PM_LOW;
        end else begin
          act.pm = PM_SHUTDOWN;
        end

        // Debounced battery choice for normal and low mode.
        if ((act.pm == PM_NORMAL || act.pm == PM_LOW) &&
            item.ext_batt_level != LEVEL_EJECTED) begin
          if (mismatch) begin
            if (mismatch_cnt_r == '0) begin
              int_higher_nxt   = !int_higher_r;
              mismatch_cnt_nxt = compare_count_r;
            end else begin
              mismatch_cnt_nxt = mismatch_cnt_r - 7'd1;
            end
          end else begin
            mismatch_cnt_nxt = compare_count_r;
          end
          act.bat = int_higher_nxt ? BAT_INT : BAT_EXT;
        end

        if (act.report) enter_req_nxt = 1'b0;
        if (act.pm == PM_EMERGENCY) begin
          in_emergency_nxt = 1'b1;
          exit_req_nxt     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_count_r <= COMPARE_COUNT_RST;
      normal_level_r  <= NORMAL_LEVEL_RST;
      low_level_r     <= LOW_LEVEL_RST;
      in_emergency_r  <= 1'b0;
      enter_req_r     <= 1'b0;
      exit_req_r      <= 1'b0;
      int_higher_r    <= 1'b1;
      mismatch_cnt_r  <= COMPARE_COUNT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMPARE_COUNT: compare_count_r <= cfg_data;
          CFG_NORMAL_LEVEL:  normal_level_r  <= cfg_data[2:0];
          CFG_LOW_LEVEL:     low_level_r     <= cfg_data[2:0];
          default:           ;
        endcase
      end
      in_emergency_r <= in_emergency_nxt;
      enter_req_r    <= enter_req_nxt;
      exit_req_r     <= exit_req_nxt;
      int_higher_r   <= int_higher_nxt;
      mismatch_cnt_r <= mismatch_cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/ppmc_queue.sv =====
// Small action queue between front and back.
module ppmc_queue import ppmc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  action_t push_data,
  input  logic    pop,
  output action_t head,
  output logic    head_valid,
  output logic    full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  action_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

// ===== hw/rtl/ppmc_back.sv =====
// Each action yields its results in an output register, one per cycle unless stalled.
module ppmc_back import ppmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  action_t   head,
  input  logic      head_valid,
  output logic      head_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic      out_valid_r;
  out_item_t out_item_r;
  logic [2:0] step_r, step_nxt;
  logic [2:0] eff_step;
  logic       load;
  out_item_t  res;

  // A mode action without a report starts at the source command.
  assign eff_step = (head.act == ACT_MODE && !head.report && step_r == STEP_REPORT) ?
                    STEP_SOURCE : step_r;

  always_comb begin
    res = '0;
    case (head.act)
      ACT_ACK: begin
        res.kind = KIND_ACK;
        res.last = 1'b1;
      end
      ACT_EXIT: begin
        case (eff_step)
          STEP_SOL_OFF: begin
            res.kind      = KIND_EXTRA;
            res.extra_cmd = EXTRA_SOL_OFF;
          end
          STEP_UNMUTE: begin
            res.kind = KIND_MUTE;
          end
          STEP_A5V_CLR: begin
            res.kind      = KIND_EXTRA;
            res.extra_cmd = EXTRA_A5V_CLR;
          end
          default: begin
            res.kind           = KIND_SOURCE;
            res.input_source   = SRC_DC;
            res.battery_source = BAT_INT;
            res.last           = 1'b1;
          end
        endcase
      end
      default: begin
        case (eff_step)
          STEP_REPORT: begin
            res.kind     = KIND_REPORT;
            res.pwr_mode = head.pm;
            res.last     = (head.pm == PM_SHUTDOWN);
          end
          STEP_SOURCE: begin
            res.kind           = KIND_SOURCE;
            res.input_source   = head.src;
            res.battery_source = head.bat;
          end
          STEP_CHARGER: begin
            res.kind      = KIND_EXTRA;
            res.extra_cmd = head.extra;
            res.last      = (head.pm != PM_EMERGENCY);
          end
          STEP_SOL_ON: begin
            res.kind      = KIND_EXTRA;
            res.extra_cmd = EXTRA_SOL_ON;
          end
          STEP_A5V_SET: begin
            res.kind      = KIND_EXTRA;
            res.extra_cmd = EXTRA_A5V_SET;
          end
          default: begin
            res.kind = KIND_MUTE;
            res.mute = 1'b1;
            res.last = 1'b1;
          end
        endcase
      end
    endcase
  end

  assign load     = head_valid && (!out_valid_r || out_pop);
  assign head_pop = load && res.last;
  assign step_nxt = res.last ? STEP_REPORT : eff_step + 3'd1;

  always_ff @(posedge clk) begin
    if (load) out_item_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= STEP_REPORT;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= step_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/power_path_mode_controller.sv =====
// Power-path mode controller. Each input item is either a periodic tick
// (plug flags, battery levels and voltages) or an emergency enter/exit
// request; it yields zero to six result items, the final one marked by
// last. The front stage takes one item per clock whenever in_full is low
// and updates all mode state right away, so the next item sees it at once.
// The back stage drains result items at one per clock, as long as out_pop
// takes each one, through a single output register. An ack or a shutdown
// tick yields one result, other active ticks two or three, an emergency
// exit four, an emergency entry six and an idle emergency tick none.
// QUEUE_DEPTH actions buffer between the two, so input and output stall
// independently.
// Configuration (cfg_we/cfg_index/cfg_data) is meant to be written while
// the block is idle; a new compare_count is used at the next counter reload.
module power_path_mode_controller import ppmc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input queue side
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  // result queue side
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    take;
  logic    act_valid;
  action_t act;
  action_t head;
  logic    head_valid;
  logic    head_pop;

  // Accept an item whenever the action queue has room.
  assign take = in_push && !in_full;

  // Classify the item and advance mode state.
  ppmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (in_item),
    .act_valid (act_valid),
    .act       (act)
  );

  // Hold pending actions between front and back.
  ppmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (act_valid),
    .push_data  (act),
    .pop        (head_pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (in_full)
  );

  // Play each action out as result items.
  ppmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_item   (out_item)
  );

endmodule

// ===== hw/rtl/ppmc_checker.sv =====
`include "power_path_mode_controller_defines.svh"

// Port-level checks on the controller.
module ppmc_checker import ppmc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  logic closes_item;
  logic is_report;

  assign closes_item = out_item.kind == KIND_ACK ||
                       (out_item.kind == KIND_REPORT && out_item.pwr_mode == PM_SHUTDOWN);
  assign is_report   = !out_empty && out_item.kind == KIND_REPORT;

  // Both queues come out of reset empty.
  `PPMC_ASSERT_NOW(a_reset_empty, !$past(rst_n), out_empty && !in_full)
  // A waiting item holds until taken.
  `PPMC_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_item))
  // An ack or a shutdown report always closes its item.
  `PPMC_ASSERT_NOW(a_ack_last, !out_empty && closes_item, out_item.last)
  // A report never announces the no-mode code.
  `PPMC_ASSERT_NOW(a_report_mode, is_report, out_item.pwr_mode != PM_NONE)

endmodule

bind power_path_mode_controller ppmc_checker u_ppmc_checker (.*);
